// ===== design/button_press_hold_release_events_top_defines.svh =====
// assertion macros for the button event detector checker
// needs clk and rst_n in the scope of each use
`ifndef BUTTON_PRESS_HOLD_RELEASE_EVENTS_TOP_DEFINES_SVH
`define BUTTON_PRESS_HOLD_RELEASE_EVENTS_TOP_DEFINES_SVH

// checked outside reset only
`define BPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BPE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bpe_pkg.sv =====
// shared types and constants for the button event detector
// no dependencies
package bpe_pkg;

    localparam int NUM_BUTTONS = 7;
    localparam int IDX_W = 3;
    localparam int TIME_W = 32;
    localparam int THR_W = 16;

    localparam logic [THR_W-1:0] HOLD_DEFAULT_MS = 16'd800;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_HOLD    = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic              valid;
        event_kind_t       kind;
        logic [TIME_W-1:0] dur;
    } lane_event_t;

endpackage

// ===== design/bpe_tick_if.sv =====
// input channel: one poll tick per item
// depends on bpe_pkg
interface bpe_tick_if;
    import bpe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TIME_W-1:0]      time_ms;
    logic [NUM_BUTTONS-1:0] pressed_levels;

    modport source (output valid, output time_ms, output pressed_levels, input ready);
    modport sink (input valid, input time_ms, input pressed_levels, output ready);
endinterface

// ===== design/bpe_event_if.sv =====
// output channel: one button event per item
// depends on bpe_pkg
interface bpe_event_if;
    import bpe_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  button_index;
    logic [1:0]        event_kind;
    logic [TIME_W-1:0] duration_ms;
    logic              last_event;

    modport source (output valid, output button_index, output event_kind,
                    output duration_ms, output last_event, input ready);
    modport sink (input valid, input button_index, input event_kind,
                  input duration_ms, input last_event, output ready);
endinterface

// ===== design/button_press_hold_release_events_top.sv =====
// a tick's lane events are registered as pending, then move one at a time into
// the output register that drives evt; throughput: one event per cycle while
// evt is ready, at most 7 events per tick; the next tick is taken in the cycle
// its predecessor's last event moves into the output register
// reset: asynchronous, clears levels, hold marks, start times, pending events;
// the hold threshold returns to 800 ms
module button_press_hold_release_events_top
    import bpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bpe_tick_if.sink         tick,
    bpe_event_if.source      evt,
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data
);

    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_eff;
    logic             tick_ready;
    logic             load;
    lane_event_t      lane_ev [NUM_BUTTONS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= HOLD_DEFAULT_MS;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // a zero threshold acts as one
    assign thr_eff    = (thr_reg == '0) ? THR_W'(1) : thr_reg;
    assign tick.ready = tick_ready;
    assign load       = tick.valid && tick_ready;

    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_lane
        bpe_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load),
            .now   (tick.time_ms),
            .level (tick.pressed_levels[g]),
            .thr   (thr_eff),
            .ev    (lane_ev[g])
        );
    end

    bpe_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .lane_ev (lane_ev),
        .ready   (tick_ready),
        .evt     (evt)
    );

endmodule

// ===== design/bpe_lane.sv =====
// one button lane: edge detect, press timer and hold mark
// depends on bpe_pkg
module bpe_lane
    import bpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [TIME_W-1:0] now,
    input  logic              level,
    input  logic [THR_W-1:0]  thr,
    output lane_event_t       ev
);

    logic              prev_reg, prev_next;
    logic              mark_reg, mark_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] held;

    assign held = now - start_reg;

    always_comb
    begin
        ev         = '0;
        ev.kind    = KIND_PRESS;
        prev_next  = level;
        mark_next  = mark_reg;
        start_next = start_reg;
        if (level && !prev_reg)
        begin
            ev.valid   = 1'b1;
            ev.kind    = KIND_PRESS;
            start_next = now;
            mark_next  = 1'b0;
        end
        else if (!level && prev_reg)
        begin
            ev.valid  = 1'b1;
            ev.kind   = KIND_RELEASE;
            ev.dur    = held;
            mark_next = 1'b0;
        end
        else if (level && !mark_reg && (held >= {{(TIME_W-THR_W){1'b0}}, thr}))
        begin
            ev.valid  = 1'b1;
            ev.kind   = KIND_HOLD;
            ev.dur    = held;
            mark_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            mark_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (load)
        begin
            prev_reg  <= prev_next;
            mark_reg  <= mark_next;
            start_reg <= start_next;
        end
    end

endmodule

// ===== design/bpe_merge.sv =====
// merge stage: holds one tick's lane events and sends them in index order
// depends on bpe_pkg and bpe_event_if
module bpe_merge
    import bpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  lane_event_t lane_ev [NUM_BUTTONS],
    output logic        ready,
    bpe_event_if.source evt
);

    logic [NUM_BUTTONS-1:0] pend_reg, pend_next;
    event_kind_t            kind_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      dur_reg  [NUM_BUTTONS];

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_index_reg;
    event_kind_t       out_kind_reg;
    logic [TIME_W-1:0] out_dur_reg;
    logic              out_last_reg;

    logic [NUM_BUTTONS-1:0] sel_mask;
    logic [NUM_BUTTONS-1:0] pend_left;
    logic [NUM_BUTTONS-1:0] lane_valid;
    logic [IDX_W-1:0]       sel_idx;
    logic                   found;
    logic                   advance;

    // lowest pending lane goes first
    always_comb
    begin
        sel_idx  = '0;
        sel_mask = '0;
        found    = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (pend_reg[i] && !found)
            begin
                sel_idx     = IDX_W'(i);
                sel_mask[i] = 1'b1;
                found       = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            lane_valid[i] = lane_ev[i].valid;
        end
    end

    assign advance        = (|pend_reg) && (!out_valid_reg || evt.ready);
    assign pend_left      = advance ? (pend_reg & ~sel_mask) : pend_reg;
    assign ready          = (pend_left == '0);
    assign pend_next      = load ? lane_valid : pend_left;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !evt.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                kind_reg[i] <= lane_ev[i].kind;
                dur_reg[i]  <= lane_ev[i].dur;
            end
        end
        if (advance)
        begin
            out_index_reg <= sel_idx;
            out_kind_reg  <= kind_reg[sel_idx];
            out_dur_reg   <= dur_reg[sel_idx];
            out_last_reg  <= (pend_left == '0);
        end
    end

    assign evt.valid        = out_valid_reg;
    assign evt.button_index = out_index_reg;
    assign evt.event_kind   = out_kind_reg;
    assign evt.duration_ms  = out_dur_reg;
    assign evt.last_event   = out_last_reg;

endmodule

// ===== design/bpe_checker.sv =====
// port-level checks for the button event detector, bound to the top level
// depends on bpe_pkg and the defines header
`include "button_press_hold_release_events_top_defines.svh"

module bpe_checker
    import bpe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              evt_valid,
    input logic              evt_ready,
    input logic [IDX_W-1:0]  evt_index,
    input logic [1:0]        evt_kind,
    input logic [TIME_W-1:0] evt_dur,
    input logic              evt_last
);

    `BPE_ASSERT(a_evt_hold, evt_valid && !evt_ready |=> evt_valid && $stable(evt_index) && $stable(evt_kind) && $stable(evt_dur) && $stable(evt_last), "stalled event changed")

    `BPE_ASSERT(a_evt_codes, evt_valid |-> (evt_kind != 2'd3) && (evt_index < IDX_W'(NUM_BUTTONS)), "event kind or index out of range")

    `BPE_ASSERT(a_press_zero, evt_valid && (evt_kind == KIND_PRESS) |-> (evt_dur == '0), "press event with nonzero duration")

    `BPE_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !evt_valid, "event valid during reset")

endmodule

bind button_press_hold_release_events_top bpe_checker u_bpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .evt_index (evt.button_index),
    .evt_kind  (evt.event_kind),
    .evt_dur   (evt.duration_ms),
    .evt_last  (evt.last_event)
);
